### rtl/flp_pkg.sv
`default_nettype none

package flp_pkg;

  localparam int ACC_WIDTH_DEF = 64;
  localparam int MUL_W         = 64;
  localparam int HALF_W        = 32;
  localparam int PROD_W        = 128;
  localparam int OUT_W         = 63;
  localparam int Q_DEPTH       = 2;

  localparam logic [MUL_W-1:0] KILO_SCALE = 64'd1000;
  localparam logic [MUL_W-1:0] MEGA_SCALE = 64'd1000000;
  localparam logic [MUL_W-1:0] UNIT_SCALE = 64'd1;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_POINT,
    CLS_SEP,
    CLS_SLASH,
    CLS_KILO,
    CLS_MEGA,
    CLS_BAD,
    CLS_END
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
  } item_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SYNTAX,
    ST_ZERO_DEN,
    ST_OVERFLOW
  } status_e;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_KILO,
    UNIT_MEGA
  } unit_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_ADD,
    BK_MUL2,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

### rtl/flp_front.sv
`default_nettype none

module flp_front
  import flp_pkg::*;
(
  input  wire logic       mode_i,
  input  wire logic [7:0] char_code_i,
  output item_t           item_o
);

  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChKilo  = 8'h6B;
  localparam logic [7:0] ChMega  = 8'h4D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  always_comb begin
    // ASCII digits carry their value in the low nibble
    item_o.digit = char_code_i[3:0];
    if (mode_i) begin
      item_o.cls = CLS_END;
    end else if (char_code_i >= ChZero && char_code_i <= ChNine) begin
      item_o.cls = CLS_DIGIT;
    end else if (char_code_i == ChPoint) begin
      item_o.cls = CLS_POINT;
    end else if (char_code_i == ChSpace || char_code_i == ChUnder) begin
      item_o.cls = CLS_SEP;
    end else if (char_code_i == ChSlash) begin
      item_o.cls = CLS_SLASH;
    end else if (char_code_i == ChKilo) begin
      item_o.cls = CLS_KILO;
    end else if (char_code_i == ChMega) begin
      item_o.cls = CLS_MEGA;
    end else begin
      item_o.cls = CLS_BAD;
    end
  end

endmodule

`default_nettype wire

### rtl/flp_fifo.sv
`default_nettype none

module flp_fifo
  import flp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output item_t      item_o
);

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);

  item_t           mem_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/flp_mul.sv
`default_nettype none

module flp_mul
  import flp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic [MUL_W-1:0]  a_q, b_q;
  logic [1:0]        cnt_q;
  logic              busy_q;
  logic [MUL_W-1:0]  pp_q;
  logic [1:0]        pp_sh_q;
  logic              pp_v_q, pp_last_q;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic              done_q;
  logic [HALF_W-1:0] a_half, b_half;

  // partial product index: cnt[1] picks the half of a, cnt[0] the half of b
  assign a_half = cnt_q[1] ? a_q[MUL_W-1:HALF_W] : a_q[HALF_W-1:0];
  assign b_half = cnt_q[0] ? b_q[MUL_W-1:HALF_W] : b_q[HALF_W-1:0];

  always_comb begin
    case (pp_sh_q)
      2'd0:    acc_d = acc_q + PROD_W'(pp_q);
      2'd1:    acc_d = acc_q + (PROD_W'(pp_q) << HALF_W);
      2'd2:    acc_d = acc_q + (PROD_W'(pp_q) << MUL_W);
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      pp_v_q    <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pp_v_q    <= busy_q;
      pp_last_q <= busy_q && (cnt_q == 2'd3);
      done_q    <= pp_v_q && pp_last_q;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (pp_v_q) begin
      acc_q <= acc_d;
    end
    pp_q    <= MUL_W'(a_half) * MUL_W'(b_half);
    pp_sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

### rtl/flp_back.sv
`default_nettype none

module flp_back
  import flp_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire item_t            item_i,
  output logic                  pop_o,
  output mul_req_t              mul_req_o,
  input  wire mul_rsp_t         mul_rsp_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [OUT_W-1:0]      numerator_o,
  output logic [OUT_W-1:0]      denominator_o,
  output logic [1:0]            status_o
);

  localparam int V = ACC_WIDTH - 1;

  back_state_e   state_q, state_d;
  logic [V-1:0]  dig_q, dig_d;
  logic [V-1:0]  den_q, den_d;
  logic [V-1:0]  int_q, int_d;
  logic [V-1:0]  num_q, num_d;
  unit_e         unit_q, unit_d;
  logic          pt_q, pt_d;
  logic          sep_q, sep_d;
  logic          sl_q, sl_d;
  status_e       sticky_q, sticky_d;
  status_e       st_q, st_d;
  logic          ovf_q, ovf_d;

  logic          out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_num_q, out_num_d;
  logic [OUT_W-1:0] out_den_q, out_den_d;
  status_e       out_st_q, out_st_d;

  logic          take;
  logic          out_free;
  logic          end_go;
  logic [V+3:0]  dig_next, den_next, den_scaled;
  logic [V:0]    sum;
  logic          prod_ovf;
  logic [MUL_W-1:0] unit_val;

  assign take     = (state_q == BK_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign end_go   = (sticky_q == ST_OK) && (den_q != '0);

  // x*10 + d as (x<<3) + (x<<1) + d; the value limit is all ones in V bits
  assign dig_next   = (V+4)'({dig_q, 3'b000}) + (V+4)'({dig_q, 1'b0}) + (V+4)'(item_i.digit);
  assign den_scaled = (V+4)'({den_q, 3'b000}) + (V+4)'({den_q, 1'b0});
  assign den_next   = den_scaled + (V+4)'(item_i.digit);
  assign sum        = (V+1)'(dig_q) + (V+1)'(num_q);
  assign prod_ovf   = |mul_rsp_i.prod[PROD_W-1:V];

  always_comb begin
    case (unit_q)
      UNIT_KILO: unit_val = KILO_SCALE;
      UNIT_MEGA: unit_val = MEGA_SCALE;
      default:   unit_val = UNIT_SCALE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (take && item_i.cls == CLS_END) begin
          state_d = end_go ? BK_MUL1 : BK_OUT;
        end
      end
      BK_MUL1: begin
        if (mul_rsp_i.done) begin
          state_d = BK_ADD;
        end
      end
      BK_ADD: state_d = BK_MUL2;
      BK_MUL2: begin
        if (mul_rsp_i.done) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    dig_d       = dig_q;
    den_d       = den_q;
    int_d       = int_q;
    num_d       = num_q;
    unit_d      = unit_q;
    pt_d        = pt_q;
    sep_d       = sep_q;
    sl_d        = sl_q;
    sticky_d    = sticky_q;
    st_d        = st_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_st_d    = out_st_q;
    pop_o       = 1'b0;
    mul_req_o.start = 1'b0;
    mul_req_o.a     = MUL_W'(int_q);
    mul_req_o.b     = MUL_W'(den_q);

    case (state_q)
      BK_IDLE: begin
        pop_o = q_valid_i;
        if (take) begin
          if (item_i.cls == CLS_END) begin
            ovf_d = 1'b0;
            if (sticky_q != ST_OK) begin
              st_d = sticky_q;
            end else if (den_q == '0) begin
              st_d = ST_ZERO_DEN;
            end else begin
              st_d = ST_OK;
              mul_req_o.start = 1'b1;
            end
          end else if (sticky_q == ST_OK) begin
            case (item_i.cls)
              CLS_POINT: begin
                if (pt_q || sep_q || sl_q) begin
                  sticky_d = ST_SYNTAX;
                end else begin
                  pt_d = 1'b1;
                end
              end
              CLS_SEP: begin
                if (pt_q || sep_q || sl_q) begin
                  sticky_d = ST_SYNTAX;
                end else begin
                  sep_d = 1'b1;
                  int_d = dig_q;
                  dig_d = '0;
                end
              end
              CLS_SLASH: begin
                if (pt_q || sl_q) begin
                  sticky_d = ST_SYNTAX;
                end else begin
                  sl_d  = 1'b1;
                  den_d = '0;
                end
              end
              CLS_KILO, CLS_MEGA: begin
                if (unit_q != UNIT_NONE) begin
                  sticky_d = ST_SYNTAX;
                end else begin
                  unit_d = (item_i.cls == CLS_KILO) ? UNIT_KILO : UNIT_MEGA;
                end
              end
              CLS_DIGIT: begin
                if (sl_q) begin
                  den_d = den_next[V-1:0];
                  if (|den_next[V+3:V]) begin
                    sticky_d = ST_OVERFLOW;
                  end
                end else begin
                  dig_d = dig_next[V-1:0];
                  if (pt_q) begin
                    den_d = den_scaled[V-1:0];
                  end
                  if ((|dig_next[V+3:V]) || (pt_q && (|den_scaled[V+3:V]))) begin
                    sticky_d = ST_OVERFLOW;
                  end
                end
              end
              default: sticky_d = ST_SYNTAX;
            endcase
          end
        end
      end
      BK_MUL1: begin
        if (mul_rsp_i.done) begin
          num_d = mul_rsp_i.prod[V-1:0];
          ovf_d = ovf_q || prod_ovf;
        end
      end
      BK_ADD: begin
        num_d           = sum[V-1:0];
        ovf_d           = ovf_q || sum[V];
        mul_req_o.start = 1'b1;
        mul_req_o.a     = MUL_W'(sum[V-1:0]);
        mul_req_o.b     = unit_val;
      end
      BK_MUL2: begin
        if (mul_rsp_i.done) begin
          num_d = mul_rsp_i.prod[V-1:0];
          if (ovf_q || prod_ovf) begin
            st_d = ST_OVERFLOW;
          end
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_num_d   = (st_q == ST_OK) ? OUT_W'(num_q) : '0;
          out_den_d   = (st_q == ST_OK) ? OUT_W'(den_q) : '0;
          // literal done: back to the empty parse state
          dig_d    = '0;
          den_d    = V'(1);
          int_d    = '0;
          unit_d   = UNIT_NONE;
          pt_d     = 1'b0;
          sep_d    = 1'b0;
          sl_d     = 1'b0;
          sticky_d = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      dig_q       <= '0;
      den_q       <= V'(1);
      int_q       <= '0;
      unit_q      <= UNIT_NONE;
      pt_q        <= 1'b0;
      sep_q       <= 1'b0;
      sl_q        <= 1'b0;
      sticky_q    <= ST_OK;
      st_q        <= ST_OK;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dig_q       <= dig_d;
      den_q       <= den_d;
      int_q       <= int_d;
      unit_q      <= unit_d;
      pt_q        <= pt_d;
      sep_q       <= sep_d;
      sl_q        <= sl_d;
      sticky_q    <= sticky_d;
      st_q        <= st_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o   = out_valid_q;
  assign numerator_o   = out_num_q;
  assign denominator_o = out_den_q;
  assign status_o      = out_st_q;

endmodule

`default_nettype wire

### rtl/fraction_literal_parser.sv
// Channel | Direction | Handshake                   | Payload
// in      | in        | in_valid_i / in_stall_o     | mode_i, char_code_i
// out     | out       | out_valid_o / out_stall_i   | numerator_o, denominator_o, status_o
//
// Characters flow one per cycle while the back end is idle;
// the two-entry queue holds up to two items while the back end is busy.
// An end item holds the back end through the take, two 64x64 products (each
// four 32x32 partial products through one multiplier), an add and the output
// load. An end item with an error status goes from the take to the output load.
// Reset clears the queue, the parse state and the output valid flag.
// A stalled output holds the back end at the end item; the queue then fills.
`default_nettype none

module fraction_literal_parser
  import flp_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             mode_i,
  input  wire logic [7:0]       char_code_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [OUT_W-1:0]      numerator_o,
  output logic [OUT_W-1:0]      denominator_o,
  output logic [1:0]            status_o
);

  item_t    front_item;
  item_t    q_item;
  logic     q_full, q_valid, q_pop;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign in_stall_o = q_full;

  flp_front u_front (
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .item_o      (front_item)
  );

  flp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  flp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  flp_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .mul_req_o     (mul_req),
    .mul_rsp_i     (mul_rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire
